[design/tbl_pkg.sv]
// Package for the thermistor beta linearizer.
// Types and constants shared by every module, and the log2 helper functions.
// No dependencies.
`default_nettype none
package tbl_pkg;

  localparam int unsigned ADC_BITS_DEF = 10;
  localparam int unsigned LOG_STEPS    = 16;
  localparam int unsigned N_LANES      = 4;
  localparam int unsigned LOG_IN_W     = 20;
  localparam int unsigned DIV_BITS     = 37;
  localparam int unsigned DEN_W        = 23;

  localparam logic [19:0] R_SERIES_RST  = 20'd10000;
  localparam logic [19:0] R_NOMINAL_RST = 20'd10000;
  localparam logic [13:0] BETA_RST      = 14'd3950;

  // ln2 in Q30 split into 15-bit halves
  localparam logic [14:0] LN2_HI   = 15'd22713;
  localparam logic [14:0] LN2_LO   = 15'd1534;
  // 2^44 / 29815 rounded down, used for the beta/298.15 term
  localparam logic [29:0] RECIP_M  = 30'd590044811;
  localparam logic [14:0] K29815   = 15'd29815;
  localparam logic [14:0] K24115   = 15'd24115;
  localparam logic [13:0] K14907   = 14'd14907;
  localparam logic [7:0]  K219     = 8'd219;
  localparam logic [6:0]  K100     = 7'd100;
  localparam logic [16:0] Q_MAX    = 17'd60082;
  localparam logic [16:0] K_OFFSET = 17'd27315;
  localparam logic [15:0] TEMP_SAT = 16'h7fff;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] REG_R_SERIES  = 2'd0;
  localparam logic [1:0] REG_R_NOMINAL = 2'd1;
  localparam logic [1:0] REG_BETA      = 2'd2;

  typedef struct packed {
    logic [31:0] m;
    logic [4:0]  e;
    logic [15:0] frac;
  } lane_t;

  typedef struct packed {
    logic                vld;
    logic                zero;
    logic [13:0]         beta;
    lane_t [N_LANES-1:0] lane;
  } log_stage_t;

  typedef struct packed {
    logic                vld;
    logic                zero;
    logic                sat;
    logic [DEN_W-1:0]    rem;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] quo;
    logic [DEN_W-1:0]    den;
  } div_stage_t;

  // integer part and Q31 mantissa; zero reads as one
  function automatic lane_t log_norm(input logic [LOG_IN_W-1:0] x);
    lane_t               r;
    logic [LOG_IN_W-1:0] xn;
    logic [4:0]          e;
    xn = (x == '0) ? LOG_IN_W'(1) : x;
    e  = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (xn[i]) e = 5'(i);
    end
    r.e    = e;
    r.m    = 32'(xn) << (5'd31 - e);
    r.frac = '0;
    return r;
  endfunction

  // one squaring step: yields the next fraction bit
  function automatic lane_t log_step(input lane_t a);
    lane_t       r;
    logic [63:0] sq;
    logic [32:0] t;
    sq = 64'(a.m) * 64'(a.m);
    t  = sq[63:31];
    r  = a;
    if (t[32]) begin
      r.m    = t[32:1];
      r.frac = {a.frac[14:0], 1'b1};
    end else begin
      r.m    = t[31:0];
      r.frac = {a.frac[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/tbl_log_cell.sv]
// One squaring cell of the log2 chain, all four operand lanes.
// Depends on tbl_pkg.
`default_nettype none
module tbl_log_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire tbl_pkg::log_stage_t a_i,
  output tbl_pkg::log_stage_t      a_o
);
  import tbl_pkg::*;

  log_stage_t a_d, a_q;

  always_comb begin
    a_d = a_i;
    for (int i = 0; i < N_LANES; i++) begin
      a_d.lane[i] = log_step(a_i.lane[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
    end
  end

  assign a_o = a_q;

endmodule
`default_nettype wire

[design/tbl_div_cell.sv]
// One restoring division cell: one quotient bit per cell.
// Depends on tbl_pkg.
`default_nettype none
module tbl_div_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire tbl_pkg::div_stage_t a_i,
  output tbl_pkg::div_stage_t      a_o
);
  import tbl_pkg::*;

  div_stage_t     a_d, a_q;
  logic [DEN_W:0] r2;

  always_comb begin
    a_d = a_i;
    r2  = {a_i.rem, a_i.num[DIV_BITS-1]};
    a_d.num = {a_i.num[DIV_BITS-2:0], 1'b0};
    if (r2 >= {1'b0, a_i.den}) begin
      a_d.rem = DEN_W'(r2 - {1'b0, a_i.den});
      a_d.quo = {a_i.quo[DIV_BITS-2:0], 1'b1};
    end else begin
      a_d.rem = r2[DEN_W-1:0];
      a_d.quo = {a_i.quo[DIV_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
    end
  end

  assign a_o = a_q;

endmodule
`default_nettype wire

[design/thermistor_beta_linearizer.sv]
// Top level: NTC thermistor linearizer, APB registers and stream ports.
// Depends on tbl_pkg, tbl_log_cell, tbl_div_cell.
//
//  port group  direction  payload
//  s_axis      in         tdata: adc_code
//  m_axis      out        tdata: temp_centi_c, tuser: status
//  apb         in/out     r_series @0, r_nominal @4, beta_kelvin @8
//
// One item per cycle while the chain moves; the stages are: normalise, 16 log2
// squaring cells, 4 arithmetic stages, 37 division cells and the output register.
// The chain moves whenever the output register is free or taken, or the last
// division cell holds a bubble; s_axis_tready shows that.
// Reset clears valid bits and restores the register defaults.
`default_nettype none
module thermistor_beta_linearizer #(
  parameter int unsigned ADC_BITS = tbl_pkg::ADC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]    s_axis_tdata,  // adc_code
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [15:0]                           m_axis_tdata,  // temp_centi_c
  output logic [1:0]                            m_axis_tuser,  // status
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [3:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import tbl_pkg::*;

  logic [19:0] r_series_q, r_nominal_q;
  logic [13:0] beta_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_series_q  <= R_SERIES_RST;
      r_nominal_q <= R_NOMINAL_RST;
      beta_q      <= BETA_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_R_SERIES:  r_series_q  <= pwdata[19:0];
        REG_R_NOMINAL: r_nominal_q <= pwdata[19:0];
        REG_BETA:      beta_q      <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_R_SERIES:  prdata = 32'(r_series_q);
      REG_R_NOMINAL: prdata = 32'(r_nominal_q);
      REG_BETA:      prdata = 32'(beta_q);
      default:       prdata = '0;
    endcase
  end

  logic                en;
  logic                out_en;
  logic                out_vld_q;
  div_stage_t          dv [DIV_BITS+1];
  log_stage_t          lg [LOG_STEPS+1];
  log_stage_t          lg0_d;
  logic [ADC_BITS-1:0] code, fsc;

  assign out_en        = ~out_vld_q | m_axis_tready;
  assign en            = out_en | ~dv[DIV_BITS].vld;
  assign s_axis_tready = en;

  assign code = s_axis_tdata[ADC_BITS-1:0];
  assign fsc  = ADC_BITS'(~code + 1'b1);

  always_comb begin
    lg0_d.vld     = s_axis_tvalid;
    lg0_d.zero    = (code == '0);
    lg0_d.beta    = beta_q;
    lg0_d.lane[0] = log_norm(r_series_q);
    lg0_d.lane[1] = log_norm(LOG_IN_W'(code));
    lg0_d.lane[2] = log_norm(LOG_IN_W'(fsc));
    lg0_d.lane[3] = log_norm(r_nominal_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg[0] <= '0;
    end else if (en) begin
      lg[0] <= lg0_d;
    end
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    tbl_log_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .a_i   (lg[g]),
      .a_o   (lg[g+1])
    );
  end

  // stage 1: log sum, beta products
  logic              p1_vld_q, p1_zero_q, p1_neg_q;
  logic [21:0]       p1_mag_q, p1_b219_q;
  logic [28:0]       p1_y_q;
  logic [20:0]       p1_b100_q;
  logic signed [22:0] l_sum;
  logic [20:0]       lv [N_LANES];

  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      lv[i] = {lg[LOG_STEPS].lane[i].e, lg[LOG_STEPS].lane[i].frac};
    end
    l_sum = $signed(23'(lv[0])) + $signed(23'(lv[1]))
          - $signed(23'(lv[2])) - $signed(23'(lv[3]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= lg[LOG_STEPS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_zero_q <= lg[LOG_STEPS].zero;
      p1_neg_q  <= l_sum[22];
      p1_mag_q  <= l_sum[22] ? 22'(-l_sum) : l_sum[21:0];
      p1_y_q    <= 29'(lg[LOG_STEPS].beta) * 29'(K24115) + 29'(K14907);
      p1_b219_q <= 22'(lg[LOG_STEPS].beta) * 22'(K219);
      p1_b100_q <= 21'(lg[LOG_STEPS].beta) * 21'(K100);
    end
  end

  // stage 2: ln2 partial products, reciprocal estimate
  logic        p2_vld_q, p2_zero_q, p2_neg_q;
  logic [36:0] p2_phi_q;
  logic [32:0] p2_plo_q;
  logic [14:0] p2_q0_q;
  logic [28:0] p2_y_q;
  logic [21:0] p2_b219_q;
  logic [20:0] p2_b100_q;
  logic [58:0] yq;

  assign yq = 59'(p1_y_q) * 59'(RECIP_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_zero_q <= p1_zero_q;
      p2_neg_q  <= p1_neg_q;
      p2_phi_q  <= 37'(p1_mag_q) * 37'(LN2_HI);
      p2_plo_q  <= 33'(p1_mag_q) * 33'(LN2_LO);
      p2_q0_q   <= yq[58:44];
      p2_y_q    <= p1_y_q;
      p2_b219_q <= p1_b219_q;
      p2_b100_q <= p1_b100_q;
    end
  end

  // stage 3: rounded ln term, reciprocal correction
  logic               p3_vld_q, p3_zero_q;
  logic signed [23:0] p3_lnq_q;
  logic [14:0]        p3_qc_q;
  logic [21:0]        p3_b219_q;
  logic [20:0]        p3_b100_q;
  logic [52:0]        ln_sum;
  logic [21:0]        ln_t;
  logic [28:0]        y_rem;

  always_comb begin
    ln_sum = (53'(p2_phi_q) << 15) + 53'(p2_plo_q) + (53'd1 << 29);
    ln_t   = ln_sum[51:30];
    y_rem  = p2_y_q - 29'(p2_q0_q) * 29'(K29815);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (en) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_zero_q <= p2_zero_q;
      p3_lnq_q  <= p2_neg_q ? -$signed(24'(ln_t)) : $signed(24'(ln_t));
      p3_qc_q   <= p2_q0_q + 15'(y_rem >= 29'(K29815));
      p3_b219_q <= p2_b219_q;
      p3_b100_q <= p2_b100_q;
    end
  end

  // stage 4: denominator and rounded dividend, into the division chain
  logic signed [24:0] den;
  logic               den_bad;
  div_stage_t         dv0_d;

  always_comb begin
    den     = $signed(25'(p3_b219_q)) + $signed(25'(p3_qc_q)) + 25'(p3_lnq_q);
    den_bad = (den <= 0);
    dv0_d.vld  = p3_vld_q;
    dv0_d.zero = p3_zero_q;
    dv0_d.sat  = den_bad;
    dv0_d.den  = den_bad ? DEN_W'(1) : den[DEN_W-1:0];
    dv0_d.rem  = '0;
    dv0_d.quo  = '0;
    dv0_d.num  = {p3_b100_q, 16'd0} + DIV_BITS'(dv0_d.den >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv[0] <= '0;
    end else if (en) begin
      dv[0] <= dv0_d;
    end
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    tbl_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .a_i   (dv[g]),
      .a_o   (dv[g+1])
    );
  end

  // output register
  logic [15:0] temp_d, temp_q;
  logic [1:0]  st_d, st_q;

  always_comb begin
    if (dv[DIV_BITS].zero) begin
      temp_d = '0;
      st_d   = ST_ZERO;
    end else if (dv[DIV_BITS].sat || dv[DIV_BITS].quo > DIV_BITS'(Q_MAX)) begin
      temp_d = TEMP_SAT;
      st_d   = ST_SAT;
    end else begin
      temp_d = 16'(dv[DIV_BITS].quo[16:0] - K_OFFSET);
      st_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= dv[DIV_BITS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      temp_q <= temp_d;
      st_q   <= st_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = temp_q;
  assign m_axis_tuser  = st_q;

endmodule
`default_nettype wire

[design/tbl_checker.sv]
// Port-level checker for the thermistor beta linearizer, with its bind.
// Depends on thermistor_beta_linearizer and tbl_pkg.
`default_nettype none
module tbl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  import tbl_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result changed under stall");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_SAT
    || m_axis_tuser == ST_ZERO))
    else $error("bad status");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_ZERO |-> m_axis_tdata == 16'd0)
    else $error("no-reading result not zero");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_SAT |-> m_axis_tdata == TEMP_SAT)
    else $error("saturated result not full scale");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |-> $signed(m_axis_tdata) >= -16'sd27315)
    else $error("temperature below zero kelvin");

endmodule

bind thermistor_beta_linearizer tbl_checker u_tbl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

[tb/tb_thermistor_beta_linearizer_chk.sv]
// Checker for the thermistor beta linearizer: watches both stream channels,
// predicts each temperature result from the live register values and compares.
// Depends on tbl_pkg for status codes and the saturation value.
module tb_thermistor_beta_linearizer_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  logic [15:0] in_data_i,
  input  logic        out_fire_i,
  input  logic [15:0] out_data_i,
  input  logic [1:0]  out_user_i,
  input  logic [19:0] r_series_i,
  input  logic [19:0] r_nominal_i,
  input  logic [13:0] beta_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          seen_o
);
  import tbl_pkg::*;

  typedef struct {
    logic [15:0] temp;
    logic [1:0]  status;
  } reading_t;

  reading_t temp_q[$];

  function automatic longint log2_fix(input longint unsigned x);
    longint unsigned m;
    int              e;
    longint          frac;
    frac = 0;
    if (x == 0) x = 1;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = x << (31 - e);
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | (64'd1 << (16 - i));
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic reading_t linearise(input logic [9:0] code);
    reading_t        r;
    longint          l, mag, lnq, d;
    longint unsigned t, num, q;
    if (code == 0) begin
      r.temp = '0;
      r.status = ST_ZERO;
      return r;
    end
    l = log2_fix(r_series_i) + log2_fix(code) - log2_fix(1024 - code)
        - log2_fix(r_nominal_i);
    mag = l < 0 ? -l : l;
    t = (longint'(mag) * 64'd744261118 + (64'd1 << 29)) >> 30;
    lnq = l < 0 ? -longint'(t) : longint'(t);
    d = longint'((longint'(beta_i) * 6553600 + 14907) / 29815) + lnq;
    r.status = ST_OK;
    if (d <= 0) begin
      r.temp = TEMP_SAT;
      r.status = ST_SAT;
    end else begin
      num = longint'(beta_i) * 6553600;
      q = (num + (d >> 1)) / d;
      if (q > 60082) begin
        r.temp = TEMP_SAT;
        r.status = ST_SAT;
      end else begin
        r.temp = 16'(longint'(q) - 27315);
      end
    end
    return r;
  endfunction

  initial begin
    fail_cnt_o = 0;
    seen_o = 0;
  end
  assign pending_o = temp_q.size();

  always @(posedge clk_i) begin
    reading_t e;
    int       errs;
    errs = 0;
    if (rst_ni) begin
      if (in_fire_i) temp_q.push_back(linearise(in_data_i[9:0]));
      if (out_fire_i) begin
        seen_o <= seen_o + 1;
        if (temp_q.size() == 0) begin
          $error("unexpected transfer: temp_centi_c %0d", $signed(out_data_i));
          errs++;
        end else begin
          e = temp_q.pop_front();
          if (e.temp !== out_data_i) begin
            $error("temp_centi_c: expected %0d actual %0d",
                   $signed(e.temp), $signed(out_data_i));
            errs++;
          end
          if (e.status !== out_user_i) begin
            $error("status: expected %0d actual %0d", e.status, out_user_i);
            errs++;
          end
        end
      end
    end
    if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
  end
endmodule

[tb/tb_thermistor_beta_linearizer.sv]
// Testbench top for the thermistor beta linearizer: clock, reset, APB writes,
// converter code stimulus and verdict. Depends on the block, tbl_pkg and the checker.
module tb_thermistor_beta_linearizer;
  import tbl_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [19:0] rs_cfg = R_SERIES_RST, rn_cfg = R_NOMINAL_RST;
  logic [13:0] beta_cfg = BETA_RST;
  int          fail_cnt, pending, seen, codes_sent;
  bit          draining = 1'b0;

  always #1 clk_i = ~clk_i;

  thermistor_beta_linearizer dut (.*);

  tb_thermistor_beta_linearizer_chk chk (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready), .in_data_i(s_axis_tdata),
    .out_fire_i(m_axis_tvalid && m_axis_tready), .out_data_i(m_axis_tdata),
    .out_user_i(m_axis_tuser), .r_series_i(rs_cfg), .r_nominal_i(rn_cfg),
    .beta_i(beta_cfg), .fail_cnt_o(fail_cnt), .pending_o(pending), .seen_o(seen));

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // receiver stalls, with calm stretches
  always @(posedge clk_i) begin
    int s;
    if (draining) m_axis_tready <= 1'b1;
    else begin
      s = $urandom_range(0, 99);
      m_axis_tready <= (s < 70) ? 1'b1 : (s < 95 ? 1'b0 : m_axis_tready);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_R_SERIES:  rs_cfg <= val[19:0];
      REG_R_NOMINAL: rn_cfg <= val[19:0];
      REG_BETA:      beta_cfg <= val[13:0];
      default: ;
    endcase
  endtask

  task automatic send_code(input logic [9:0] code, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, code};
    do @(posedge clk_i); while (!s_axis_tready);
    codes_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic random_codes(input int n);
    for (int i = 0; i < n; i++) begin
      send_code(($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 3)) :
                10'($urandom_range(0, 1023)), 1'b1);
      if (i == n / 2) settle();
    end
    settle();
  endtask

  initial begin
    logic [9:0] dir_codes[] = '{10'd0, 10'd1, 10'd2, 10'd512, 10'd1023, 10'd1022,
                                10'h155, 10'h2aa, 10'd100, 10'd900};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_codes[i]) send_code(dir_codes[i], 1'b0);
    settle();
    // extremes: low beta, huge resistance ratios, zero registers
    reg_write(REG_R_SERIES, 32'hfffff);
    reg_write(REG_R_NOMINAL, 32'd1);
    reg_write(REG_BETA, 32'd1000);
    foreach (dir_codes[i]) send_code(dir_codes[i], 1'b0);
    settle();
    reg_write(REG_R_SERIES, 32'd0);
    reg_write(REG_R_NOMINAL, 32'd1000000);
    reg_write(REG_BETA, 32'd0);
    send_code(10'd1, 1'b0); send_code(10'd1023, 1'b0); send_code(10'd0, 1'b0);
    settle();
    random_codes(300);
    reg_write(REG_BETA, 32'h3fff);
    reg_write(REG_R_SERIES, 32'd1);
    reg_write(REG_R_NOMINAL, 32'hfffff);
    random_codes(250);
    for (int p = 0; p < 4; p++) begin
      reg_write(REG_R_SERIES, $urandom_range(0, 20'hfffff));
      reg_write(REG_R_NOMINAL, $urandom_range(0, 20'hfffff));
      reg_write(REG_BETA, $urandom_range(0, 14'h3fff));
      random_codes(200);
    end
    reg_write(REG_R_SERIES, 32'd10000);
    reg_write(REG_R_NOMINAL, 32'd10000);
    reg_write(REG_BETA, 32'd3950);
    random_codes(100);
    draining = 1'b1;
    settle();
    $display("covered %0d converter codes over several register settings, %0d results",
             codes_sent, seen);
    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end
endmodule

[thermistor_beta_linearizer.f]
design/tbl_pkg.sv
design/tbl_log_cell.sv
design/tbl_div_cell.sv
design/thermistor_beta_linearizer.sv
design/tbl_checker.sv
tb/tb_thermistor_beta_linearizer_chk.sv
tb/tb_thermistor_beta_linearizer.sv
